/* sv/mmfs_pkg.sv */
// ----------------------------------------------------------------------------
// Min-max feature scaler package
// Shared constants, codes and transaction types for the min-max feature scaler.
// ----------------------------------------------------------------------------
package mmfs_pkg;

  localparam int NUM_COLUMNS = 64;
  localparam int COL_AW      = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int DATA_W      = 16;
  localparam int DIV_STEPS   = DATA_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);
  localparam int FRAC_SHIFT  = 12;
  localparam int PRE_BITS    = DATA_W - FRAC_SHIFT;

  localparam logic [1:0] REQ_TRAIN = 2'd0;
  localparam logic [1:0] REQ_SCALE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic signed [DATA_W-1:0] MIN_RESET = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] MAX_RESET = 16'sh8000;
  localparam logic [DATA_W-1:0]        Q_POS_MAX = 16'h7FFF;
  localparam logic [DATA_W-1:0]        Q_NEG_MAG = 16'h8000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [5:0]               col_index;
    logic signed [DATA_W-1:0] sample_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] scaled_value;
    logic                     saturated;
    logic                     flat_column;
  } result_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] minimum;
    logic signed [DATA_W-1:0] maximum;
  } stats_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] magnitude;
    logic [DATA_W-1:0] span;
  } div_cmd_t;

  typedef struct packed {
    logic              done;
    logic              overflow;
    logic [DATA_W-1:0] quotient;
  } div_sts_t;

endpackage

/* sv/min_max_feature_scaler.sv */
// ----------------------------------------------------------------------------
// Min-max feature scaler
// Keeps a running minimum and maximum per feature column and scales samples
// to (v - min) / (max - min) in signed Q4.12.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Training and
// clear transactions give no result, and busy falls again when the block
// leaves its execute state. A scale transaction holds busy high until its
// result is ready. Its result appears with strobe high in the cycle in which busy
// falls. For a flat column the result is made in the execute state. For one
// whose quotient the divider's up-front check finds to overflow, it follows
// the divider's done. Otherwise it waits for the radix-2 divider, which retires
// one quotient bit per cycle.
// Each result is shown for a single cycle with strobe high and cannot be held
// off by the receiver.
// ----------------------------------------------------------------------------
module min_max_feature_scaler (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mmfs_pkg::req_t    req,
  output logic              strobe,
  output mmfs_pkg::result_t result
);
  import mmfs_pkg::*;

  state_t                   state;
  state_t                   state_next;
  req_t                     req_q;
  logic [NUM_COLUMNS-1:0]   col_valid;
  logic                     neg_q;

  logic                     strobe_next;
  result_t                  result_next;
  logic                     ram_we;
  stats_t                   ram_wdata;
  logic [$bits(stats_t)-1:0] ram_rdata;
  stats_t                   rd_stats;
  logic                     valid_set;
  logic                     valid_clear;
  div_cmd_t                 div_cmd;
  div_sts_t                 div_sts;

  logic [COL_AW-1:0]        addr_q;
  logic                     col_ok;
  logic signed [DATA_W-1:0] mn;
  logic signed [DATA_W-1:0] mx;
  logic [DATA_W:0]          diff;
  logic [DATA_W:0]          diff_neg;
  logic [DATA_W:0]          span;
  logic                     flat;

  mmfs_ram #(
    .WIDTH($bits(stats_t)),
    .DEPTH(NUM_COLUMNS)
  ) u_stats_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr_q),
    .wdata(ram_wdata),
    .raddr(COL_AW'(req.col_index)),
    .rdata(ram_rdata)
  );

  mmfs_divider u_divider (
    .clk(clk),
    .rst(rst),
    .cmd(div_cmd),
    .sts(div_sts)
  );

  always_comb begin
    addr_q   = COL_AW'(req_q.col_index);
    col_ok   = (32'(req_q.col_index) < NUM_COLUMNS);
    rd_stats = stats_t'(ram_rdata);
    mn       = col_valid[addr_q] ? rd_stats.minimum : MIN_RESET;
    mx       = col_valid[addr_q] ? rd_stats.maximum : MAX_RESET;
    diff     = {req_q.sample_value[DATA_W-1], req_q.sample_value} - {mn[DATA_W-1], mn};
    diff_neg = -diff;
    span     = {mx[DATA_W-1], mx} - {mn[DATA_W-1], mn};
    flat     = !col_ok || !(mx > mn);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (req_q.req_type == REQ_SCALE && !flat) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we      = 1'b0;
    ram_wdata   = '{minimum: mn, maximum: mx};
    valid_set   = 1'b0;
    valid_clear = 1'b0;
    div_cmd     = '{start: 1'b0,
                    magnitude: diff[DATA_W] ? diff_neg[DATA_W-1:0] : diff[DATA_W-1:0],
                    span: span[DATA_W-1:0]};
    strobe_next = 1'b0;
    result_next = result;
    unique case (state)
      ST_IDLE: begin
      end
      ST_EXEC: begin
        case (req_q.req_type)
          REQ_TRAIN: begin
            if (col_ok) begin
              ram_we    = 1'b1;
              valid_set = 1'b1;
              ram_wdata.minimum = (req_q.sample_value < mn) ? req_q.sample_value : mn;
              ram_wdata.maximum = (req_q.sample_value > mx) ? req_q.sample_value : mx;
            end
          end
          REQ_CLEAR: begin
            valid_clear = 1'b1;
          end
          REQ_SCALE: begin
            if (flat) begin
              strobe_next = 1'b1;
              result_next = '{scaled_value: '0, saturated: 1'b0, flat_column: 1'b1};
            end else begin
              div_cmd.start = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_DIV: begin
        if (div_sts.done) begin
          strobe_next             = 1'b1;
          result_next.flat_column = 1'b0;
          if (neg_q) begin
            result_next.saturated    = div_sts.overflow || (div_sts.quotient > Q_NEG_MAG);
            result_next.scaled_value = result_next.saturated ? Q_NEG_MAG
                                                             : DATA_W'(-div_sts.quotient);
          end else begin
            result_next.saturated    = div_sts.overflow || (div_sts.quotient > Q_POS_MAX);
            result_next.scaled_value = result_next.saturated ? Q_POS_MAX : div_sts.quotient;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      strobe    <= 1'b0;
      col_valid <= '0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      if (valid_clear) begin
        col_valid <= '0;
      end else if (valid_set) begin
        col_valid[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (state == ST_IDLE && start) begin
      req_q <= req;
    end
    if (div_cmd.start) begin
      neg_q <= diff[DATA_W];
    end
  end

  assign busy = (state != ST_IDLE);

  assert property (@(posedge clk) disable iff (rst)
    strobe |-> ($past(state) == ST_EXEC || $past(state) == ST_DIV))
    else $error("Result strobe without a scale transaction in progress.");

  assert property (@(posedge clk) disable iff (rst)
    (strobe && result.flat_column) |-> (result.scaled_value == '0 && !result.saturated))
    else $error("Flat column result is not zero or is marked saturated.");

  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Accepted transaction did not make the block busy.");

  assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> state == ST_DIV)
    else $error("Divider finished outside the divide state.");

endmodule

/* sv/mmfs_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mmfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/mmfs_divider.sv */
// ----------------------------------------------------------------------------
// Min-max feature scaler divider
// Radix-2 restoring divider for (magnitude << 12) / span, one quotient bit
// per cycle, with an up-front check for quotients that need more than 16 bits.
// ----------------------------------------------------------------------------
module mmfs_divider (
  input  logic                clk,
  input  logic                rst,
  input  mmfs_pkg::div_cmd_t  cmd,
  output mmfs_pkg::div_sts_t  sts
);
  import mmfs_pkg::*;

  logic              active;
  logic              done;
  logic              overflow;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] shift;
  logic [DATA_W-1:0] quot;
  logic [DATA_W-1:0] span;
  logic [CNT_W-1:0]  count;

  logic [DATA_W:0]   trial;
  logic              fits;
  logic [DATA_W-1:0] rem_next;
  logic              too_big;

  always_comb begin
    trial    = {rem, shift[DATA_W-1]};
    fits     = (trial >= {1'b0, span});
    rem_next = fits ? DATA_W'(trial - {1'b0, span}) : trial[DATA_W-1:0];
    too_big  = ({{PRE_BITS{1'b0}}, cmd.magnitude} >= {cmd.span, {PRE_BITS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        overflow <= too_big;
        span     <= cmd.span;
        rem      <= DATA_W'(cmd.magnitude >> PRE_BITS);
        shift    <= {cmd.magnitude[PRE_BITS-1:0], {FRAC_SHIFT{1'b0}}};
        quot     <= '0;
        count    <= '0;
        active   <= !too_big;
        done     <= too_big;
      end else if (active) begin
        rem   <= rem_next;
        shift <= {shift[DATA_W-2:0], 1'b0};
        quot  <= {quot[DATA_W-2:0], fits};
        count <= count + 1'b1;
        if (count == CNT_W'(DIV_STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign sts = '{done: done, overflow: overflow, quotient: quot};

endmodule

/* tb/scaler_checker.sv */
// ----------------------------------------------------------------------------
// Min-max feature scaler checker
// Watches the request and result channels of the scaler. It keeps its own
// per-column minimum and maximum and works out the scaled value for every
// accepted scale transaction. It then compares each result strobe, field by
// field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module scaler_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  mmfs_pkg::req_t    req,
  input  logic              strobe,
  input  mmfs_pkg::result_t result,
  output int unsigned       mismatch_count,
  output int unsigned       results_outstanding
);
  import mmfs_pkg::*;

  localparam int PRINT_CAP = 50;

  logic signed [DATA_W-1:0] col_min [NUM_COLUMNS];
  logic signed [DATA_W-1:0] col_max [NUM_COLUMNS];
  result_t                  expected_results [$];

  function automatic result_t scale_against_stats(logic [5:0] col,
                                                  logic signed [DATA_W-1:0] v);
    result_t r;
    longint  num;
    longint  den;
    longint  q;
    r             = '0;
    r.flat_column = 1'b1;
    if (col < NUM_COLUMNS && col_max[col] > col_min[col]) begin
      num = (longint'(v) - longint'(col_min[col])) * (longint'(1) << FRAC_SHIFT);
      den = longint'(col_max[col]) - longint'(col_min[col]);
      q   = num / den;
      r.flat_column = 1'b0;
      if (q > longint'(MIN_RESET)) begin
        q           = longint'(MIN_RESET);
        r.saturated = 1'b1;
      end else if (q < longint'(MAX_RESET)) begin
        q           = longint'(MAX_RESET);
        r.saturated = 1'b1;
      end
      r.scaled_value = q[DATA_W-1:0];
    end
    return r;
  endfunction

  task automatic clear_stats();
    foreach (col_min[c]) begin
      col_min[c] = MIN_RESET;
      col_max[c] = MAX_RESET;
    end
  endtask

  task automatic fold_sample(logic [5:0] col, logic signed [DATA_W-1:0] v);
    if (col < NUM_COLUMNS) begin
      if (v < col_min[col]) col_min[col] = v;
      if (v > col_max[col]) col_max[col] = v;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < PRINT_CAP) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_stats();
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (strobe) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no transaction pending", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (result.scaled_value !== want.scaled_value)
            report_mismatch("scaled_value", int'(result.scaled_value),
                            int'(want.scaled_value));
          if (result.saturated !== want.saturated)
            report_mismatch("saturated", int'(result.saturated), int'(want.saturated));
          if (result.flat_column !== want.flat_column)
            report_mismatch("flat_column", int'(result.flat_column),
                            int'(want.flat_column));
        end
      end
      if (start && !busy) begin
        case (req.req_type)
          REQ_TRAIN: fold_sample(req.col_index, req.sample_value);
          REQ_SCALE: expected_results.insert(expected_results.size(),
                       scale_against_stats(req.col_index, req.sample_value));
          REQ_CLEAR: clear_stats();
          default: ;
        endcase
      end
    end
    results_outstanding = expected_results.size();
  end

endmodule

/* tb/min_max_feature_scaler_tb.sv */
// ----------------------------------------------------------------------------
// Min-max feature scaler testbench
// Drives directed corner cases and then random training, scale and clear
// transactions in phases with differing amounts of sender idling. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module min_max_feature_scaler_tb;
  import mmfs_pkg::*;

  localparam int         CYCLE_LIMIT  = 600000;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         PHASE_ITEMS  = 385;
  localparam logic [1:0] REQ_UNUSED   = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        strobe;
  result_t     result;
  int unsigned mismatch_count;
  int unsigned results_outstanding;
  int unsigned cycle_count = 0;
  int          idle_pct;
  logic [5:0]  hot_cols [6];
  int          col_base [NUM_COLUMNS];

  always #1 clk = ~clk;

  min_max_feature_scaler u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .strobe (strobe),
    .result (result)
  );

  scaler_checker u_check (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .req                 (req),
    .strobe              (strobe),
    .result              (result),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic issue(logic [1:0] kind, logic [5:0] col, logic signed [DATA_W-1:0] value);
    req_t r;
    r.req_type     = kind;
    r.col_index    = col;
    r.sample_value = value;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(negedge clk);
    while (results_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(int base);
    int x;
    case ($urandom_range(4))
      0: x = int'($urandom);
      1: x = base + int'($urandom_range(510)) - 255;
      2: x = base + int'($urandom_range(8190)) - 4095;
      3: x = $urandom_range(1) ? int'(MIN_RESET) : int'(MAX_RESET);
      default: x = base;
    endcase
    return x[DATA_W-1:0];
  endfunction

  task automatic random_phase(int pct);
    int         issued;
    int         sel;
    logic [5:0] col;
    idle_pct = pct;
    foreach (hot_cols[i]) hot_cols[i] = 6'($urandom_range(NUM_COLUMNS - 1));
    foreach (col_base[c]) begin
      col_base[c] = $urandom_range(1) ? int'($urandom_range(65535)) - 32768
                                      : int'($urandom_range(4000)) - 2000;
    end
    issued = 0;
    while (issued < PHASE_ITEMS) begin
      sel = $urandom_range(99);
      col = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                     : hot_cols[$urandom_range(5)];
      if (sel < 2) begin
        issue(REQ_UNUSED, 6'($urandom), 16'($urandom));
      end else begin
        if (sel < 5)       issue(REQ_CLEAR, col, 16'($urandom));
        else if (sel < 50) issue(REQ_TRAIN, col, pick_value(col_base[col]));
        else               issue(REQ_SCALE, col, pick_value(col_base[col]));
        issued++;
      end
    end
    quiesce();
  endtask

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    req      = '0;
    idle_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Untrained columns report flat.
    issue(REQ_SCALE, 6'd0, 16'sh0000);
    issue(REQ_SCALE, 6'd63, 16'sh7FFF);
    // Full-range column: both ends and the middle.
    issue(REQ_TRAIN, 6'd5, 16'sh8000);
    issue(REQ_TRAIN, 6'd5, 16'sh7FFF);
    issue(REQ_SCALE, 6'd5, 16'sh8000);
    issue(REQ_SCALE, 6'd5, 16'sh7FFF);
    issue(REQ_SCALE, 6'd5, 16'sh0000);
    // Single sample leaves the column flat.
    issue(REQ_TRAIN, 6'd7, 16'sd100);
    issue(REQ_SCALE, 6'd7, 16'sd100);
    // Narrow span saturates in both directions.
    issue(REQ_TRAIN, 6'd7, 16'sd101);
    issue(REQ_SCALE, 6'd7, 16'sh7FFF);
    issue(REQ_SCALE, 6'd7, 16'sh8000);
    issue(REQ_SCALE, 6'd7, 16'sd101);
    // Values below the minimum and truncation towards zero.
    issue(REQ_TRAIN, 6'd63, 16'sd1000);
    issue(REQ_TRAIN, 6'd63, 16'sd2000);
    issue(REQ_SCALE, 6'd63, 16'sd500);
    issue(REQ_SCALE, 6'd63, 16'sd1333);
    issue(REQ_SCALE, 6'd63, -16'sd667);
    // The unused request code must change nothing.
    issue(REQ_UNUSED, 6'd63, 16'sh8000);
    issue(REQ_SCALE, 6'd63, 16'sd1500);
    // Clear returns every column to its untrained state.
    issue(REQ_CLEAR, 6'd0, 16'sh0000);
    issue(REQ_SCALE, 6'd5, 16'sd0);
    issue(REQ_SCALE, 6'd63, 16'sd1500);
    quiesce();

    random_phase(0);
    random_phase(61);
    random_phase(34);
    random_phase(0);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/mmfs_pkg.sv
sv/mmfs_ram.sv
sv/mmfs_divider.sv
sv/min_max_feature_scaler.sv
tb/scaler_checker.sv
tb/min_max_feature_scaler_tb.sv
